@@ design/tun_pkg.sv @@
`default_nettype none

package tun_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned OutW   = 16;
  localparam int unsigned MagW   = 50;  // cross product magnitude
  localparam int unsigned NormW  = 30;  // normalized magnitude
  localparam int unsigned SumW   = 62;  // sum of squares
  localparam int unsigned RootW  = 31;  // square root of the sum
  localparam int unsigned RemW   = 33;  // square root partial remainder
  localparam int unsigned QuotW  = 15;  // quotient bits
  localparam int unsigned DivW   = 32;  // divisor, 2 * root
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned DivSteps  = 15;
  localparam logic [QuotW-1:0] UnitOne = 15'd16384;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] nx_unit;
    logic signed [OutW-1:0] ny_unit;
    logic signed [OutW-1:0] nz_unit;
    logic                   degenerate;
  } out_item_t;

  // data carried alongside the square root
  typedef struct packed {
    logic [2:0][NormW-1:0] m;
    logic [2:0]            neg;
    logic                  deg;
  } side_t;

  // one square root cell's state
  typedef struct packed {
    logic [SumW-1:0]  s;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    side_t            side;
  } sqrt_st_t;

  // one divider cell's state, three lanes sharing the divisor
  typedef struct packed {
    logic [2:0][DivW-1:0]  rem;
    logic [2:0][QuotW-1:0] low;
    logic [2:0][QuotW-1:0] q;
    logic [DivW-1:0]       d;
    logic [2:0]            neg;
    logic                  deg;
  } div_st_t;

endpackage

`default_nettype wire

@@ design/tun_front.sv @@
`default_nettype none

module tun_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  tun_pkg::in_item_t  item_i,
  output logic               vld_o,
  output tun_pkg::sqrt_st_t  st_o
);
  import tun_pkg::*;

  logic [6:0] v_q;

  logic signed [CoordW:0] e1_q [3];
  logic signed [CoordW:0] e2_q [3];
  logic signed [CoordW:0] e1_d [3];
  logic signed [CoordW:0] e2_d [3];
  logic signed [MagW-1:0] pa_q [3];
  logic signed [MagW-1:0] pb_q [3];
  logic signed [MagW:0]   cr_d [3];
  logic [MagW-1:0]        mag_d [3];
  logic [MagW-1:0]        mag_q [3];
  logic [MagW-1:0]        mag2_q [3];
  logic [2:0]             neg_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic [MagW-1:0]        or_v;
  logic [5:0]             n_d, n_q;
  logic                   deg2_q, deg3_q, deg4_q, deg5_q;
  logic [NormW-1:0]       m_q [3];
  logic [NormW-1:0]       m2_q [3];
  logic [NormW-1:0]       m3_q [3];
  logic [2*NormW-1:0]     sq_q [3];
  logic [SumW-1:0]        sum_q;
  logic [MagW+NormW-1:0]  wide [3];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], vld_i};
    end
  end

  // edge vectors a - b and b - c
  always_comb begin
    e1_d[0] = {item_i.ax[CoordW-1], item_i.ax}
            - {item_i.bx[CoordW-1], item_i.bx};
    e1_d[1] = {item_i.ay[CoordW-1], item_i.ay}
            - {item_i.by_coord[CoordW-1], item_i.by_coord};
    e1_d[2] = {item_i.az[CoordW-1], item_i.az}
            - {item_i.bz[CoordW-1], item_i.bz};
    e2_d[0] = {item_i.bx[CoordW-1], item_i.bx}
            - {item_i.cx[CoordW-1], item_i.cx};
    e2_d[1] = {item_i.by_coord[CoordW-1], item_i.by_coord}
            - {item_i.cy[CoordW-1], item_i.cy};
    e2_d[2] = {item_i.bz[CoordW-1], item_i.bz}
            - {item_i.cz[CoordW-1], item_i.cz};
  end

  // cross product terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_d[i]  = {pa_q[i][MagW-1], pa_q[i]} - {pb_q[i][MagW-1], pb_q[i]};
      mag_d[i] = cr_d[i][MagW] ? MagW'(-cr_d[i]) : cr_d[i][MagW-1:0];
    end
  end

  // length of the largest magnitude
  always_comb begin
    or_v = mag_q[0] | mag_q[1] | mag_q[2];
    n_d  = '0;
    for (int i = 0; i < MagW; i++) begin
      if (or_v[i]) n_d = 6'(i + 1);
    end
  end

  // common shift so the largest magnitude lands in [2^29, 2^30)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag2_q[i], {NormW{1'b0}}} >> n_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= e1_d[i];
        e2_q[i] <= e2_d[i];
      end
      pa_q[0] <= e1_q[1] * e2_q[2];
      pb_q[0] <= e1_q[2] * e2_q[1];
      pa_q[1] <= e1_q[2] * e2_q[0];
      pb_q[1] <= e1_q[0] * e2_q[2];
      pa_q[2] <= e1_q[0] * e2_q[1];
      pb_q[2] <= e1_q[1] * e2_q[0];
      for (int i = 0; i < 3; i++) begin
        mag_q[i]  <= mag_d[i];
        neg_q[i]  <= cr_d[i][MagW];
        mag2_q[i] <= mag_q[i];
        m_q[i]    <= wide[i][NormW-1:0];
        m2_q[i]   <= m_q[i];
        m3_q[i]   <= m2_q[i];
        sq_q[i]   <= m_q[i] * m_q[i];
      end
      n_q    <= n_d;
      deg2_q <= (or_v == '0);
      neg2_q <= neg_q;
      deg3_q <= deg2_q;
      neg3_q <= neg2_q;
      deg4_q <= deg3_q;
      neg4_q <= neg3_q;
      deg5_q <= deg4_q;
      neg5_q <= neg4_q;
      sum_q  <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    end
  end

  assign vld_o = v_q[6];

  always_comb begin
    st_o.s        = sum_q;
    st_o.rem      = '0;
    st_o.root     = '0;
    st_o.side.m   = {m3_q[2], m3_q[1], m3_q[0]};
    st_o.side.neg = neg5_q;
    st_o.side.deg = deg5_q;
  end

endmodule

`default_nettype wire

@@ design/tun_sqrt_cell.sv @@
`default_nettype none

module tun_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  tun_pkg::sqrt_st_t  st_i,
  output logic               vld_o,
  output tun_pkg::sqrt_st_t  st_o
);
  import tun_pkg::*;

  logic              v_q;
  sqrt_st_t          st_q, st_d;
  logic [RemW+1:0]   cur;
  logic [RemW+1:0]   trial;

  // one root bit: bring down two bits of the radicand, try 4*root + 1
  always_comb begin
    cur   = {st_i.rem, st_i.s[SumW-1 -: 2]};
    trial = (RemW+2)'({st_i.root, 2'b01});
    st_d      = st_i;
    st_d.s    = {st_i.s[SumW-3:0], 2'b00};
    if (cur >= trial) begin
      st_d.rem  = RemW'(cur - trial);
      st_d.root = {st_i.root[RootW-2:0], 1'b1};
    end else begin
      st_d.rem  = cur[RemW-1:0];
      st_d.root = {st_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o = v_q;
  assign st_o  = st_q;

endmodule

`default_nettype wire

@@ design/tun_div_cell.sv @@
`default_nettype none

module tun_div_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  tun_pkg::div_st_t  st_i,
  output logic              vld_o,
  output tun_pkg::div_st_t  st_o
);
  import tun_pkg::*;

  logic            v_q;
  div_st_t         st_q, st_d;
  logic [DivW:0]   cur [3];

  // one quotient bit per lane, restoring
  always_comb begin
    st_d = st_i;
    for (int i = 0; i < 3; i++) begin
      cur[i]       = {st_i.rem[i], st_i.low[i][QuotW-1]};
      st_d.low[i]  = {st_i.low[i][QuotW-2:0], 1'b0};
      if (cur[i] >= {1'b0, st_i.d}) begin
        st_d.rem[i] = DivW'(cur[i] - {1'b0, st_i.d});
        st_d.q[i]   = {st_i.q[i][QuotW-2:0], 1'b1};
      end else begin
        st_d.rem[i] = cur[i][DivW-1:0];
        st_d.q[i]   = {st_i.q[i][QuotW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o = v_q;
  assign st_o  = st_q;

endmodule

`default_nettype wire

@@ design/triangle_unit_normal_top.sv @@
// Channel | Handshake              | Payload
// --------+------------------------+-------------------------------
// in      | in_valid_i, in_ready_o | in_item_i  (nine Q15.8 coords)
// out     | out_valid_o, out_ready_i | out_item_o (Q1.14 normal, flag)
//
// One item per cycle while the output is not stalled; 7 front stages (edges, products,
// cross, length, shift, squares, sum), 31 square root cells, a divider
// setup stage, 15 divider cells and the output register.
// Reset clears all valid bits; payload registers are not reset.
// The whole pipeline moves when the output register is empty or taken;
// otherwise every stage, and in_ready_o, holds.
`default_nettype none

module triangle_unit_normal_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tun_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::out_item_t out_item_o
);
  import tun_pkg::*;

  logic      en;
  logic      sq_v  [SqrtSteps+1];
  sqrt_st_t  sq_st [SqrtSteps+1];
  logic      dv_v  [DivSteps+1];
  div_st_t   dv_st [DivSteps+1];
  logic      prep_v_q;
  div_st_t   prep_q, prep_d;
  logic [QuotW+NormW:0] num [3];
  logic      out_v_q;
  out_item_t out_q, out_d;
  logic [QuotW-1:0] r [3];
  logic [OutW-1:0]  comp [3];

  assign en         = out_ready_i | ~out_v_q;
  assign in_ready_o = en;

  tun_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .item_i (in_item_i),
    .vld_o  (sq_v[0]),
    .st_o   (sq_st[0])
  );

  // square root chain
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_v[k]),
      .st_i   (sq_st[k]),
      .vld_o  (sq_v[k+1]),
      .st_o   (sq_st[k+1])
    );
  end

  // divider setup: numerator m*2^15 + L, divisor 2L
  always_comb begin
    prep_d.d   = {sq_st[SqrtSteps].root, 1'b0};
    prep_d.neg = sq_st[SqrtSteps].side.neg;
    prep_d.deg = sq_st[SqrtSteps].side.deg;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq_st[SqrtSteps].side.m[i], {QuotW{1'b0}}}
             + (QuotW+NormW+1)'(sq_st[SqrtSteps].root);
      prep_d.rem[i] = DivW'(num[i][QuotW+NormW:QuotW]);
      prep_d.low[i] = num[i][QuotW-1:0];
      prep_d.q[i]   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= sq_v[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  assign dv_v[0]  = prep_v_q;
  assign dv_st[0] = prep_q;

  // divider chain
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    tun_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_v[k]),
      .st_i   (dv_st[k]),
      .vld_o  (dv_v[k+1]),
      .st_o   (dv_st[k+1])
    );
  end

  // saturate, apply sign, zero a degenerate normal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = (dv_st[DivSteps].q[i] > UnitOne) ? UnitOne : dv_st[DivSteps].q[i];
      if (dv_st[DivSteps].deg) begin
        comp[i] = '0;
      end else if (dv_st[DivSteps].neg[i]) begin
        comp[i] = OutW'(-{1'b0, r[i]});
      end else begin
        comp[i] = OutW'(r[i]);
      end
    end
    out_d.nx_unit    = comp[0];
    out_d.ny_unit    = comp[1];
    out_d.nz_unit    = comp[2];
    out_d.degenerate = dv_st[DivSteps].deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // degenerate normal comes out as zero
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.degenerate |->
      out_q.nx_unit == '0 && out_q.ny_unit == '0 && out_q.nz_unit == '0)
    else $error("degenerate item with nonzero normal");

  // a proper normal has at least one nonzero component
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.degenerate |->
      out_q.nx_unit != '0 || out_q.ny_unit != '0 || out_q.nz_unit != '0)
    else $error("zero normal on a proper triangle");

  // components stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |->
      out_q.nx_unit <= 16'sd16384 && out_q.nx_unit >= -16'sd16384 &&
      out_q.ny_unit <= 16'sd16384 && out_q.ny_unit >= -16'sd16384 &&
      out_q.nz_unit <= 16'sd16384 && out_q.nz_unit >= -16'sd16384)
    else $error("normal component out of range");

  // a stalled output holds its item
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i |=> out_v_q && $stable(out_q))
    else $error("output item changed while stalled");
`endif

endmodule

`default_nettype wire
